// ===== src/ph_pid_pump_controller_unit_macros.svh =====
// Assertion macros for the pH PID pump controller checker.
// No dependencies.
`ifndef PH_PID_PUMP_CONTROLLER_UNIT_MACROS_SVH
`define PH_PID_PUMP_CONTROLLER_UNIT_MACROS_SVH

// Check outside reset.
`define PHPID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check at every edge, reset included.
`define PHPID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/phpid_pkg.sv =====
// Shared widths, reset values, register codes and unit interface structs
// for the pH PID pump controller. No dependencies.
package phpid_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned PH_W    = 12;
  localparam int unsigned ERR_W   = 13;
  localparam int unsigned DERR_W  = 14;
  localparam int unsigned CTRL_W  = 9;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned INTEG_W = 16;
  localparam int unsigned ISUM_W  = INTEG_W + 2;
  localparam logic [INTEG_W-1:0] INTEG_MAX = 16'hFF00;

  localparam int unsigned DIGIT_W   = 2;
  localparam int unsigned MAC_STEPS = GAIN_W / DIGIT_W;
  localparam int unsigned MAC_CNT_W = $clog2(MAC_STEPS);
  localparam int unsigned Y_W       = 2 * GAIN_W;
  localparam int unsigned A_W       = Y_W + 1;
  localparam int unsigned MC_W      = A_W;
  localparam int unsigned ACC_W     = 50;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned NUM_W     = ACC_W - FRAC_W;

  localparam logic signed [ACC_W-1:0] A_LIM   = ACC_W'(64'sd2147483648);
  localparam logic signed [ACC_W-1:0] A_LIM_N = -A_LIM;

  localparam int unsigned QUO_W     = DUTY_W;
  localparam int unsigned DIVD_W    = GAIN_W + QUO_W;
  localparam int unsigned DIV_CNT_W = $clog2(QUO_W);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] KP_RST     = 16'd25600;
  localparam logic [GAIN_W-1:0] KI_RST     = 16'd15360;
  localparam logic [GAIN_W-1:0] KD_RST     = 16'd38400;
  localparam logic [GAIN_W-1:0] PERIOD_RST = 16'd10;
  localparam logic [PH_W-1:0]   SP_RST     = 12'd1280;

  localparam int unsigned ERR_LSB     = 0;
  localparam int unsigned CTRL_LSB    = ERR_LSB + ERR_W;
  localparam int unsigned BASE_LSB    = CTRL_LSB + CTRL_W;
  localparam int unsigned ACID_LSB    = BASE_LSB + DUTY_W;
  localparam int unsigned OUT_FIELD_W = ACID_LSB + DUTY_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_PERIOD = 3'd3,
    CFG_SP     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic [MC_W-1:0]   mcand;
    logic [GAIN_W-1:0] mult;
  } mac_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [GAIN_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== src/ph_pid_pump_controller_unit.sv =====
// pH PID pump controller top level; uses phpid_pkg, phpid_mac, phpid_div.
// A sample beat is taken only in the idle state. Without an update the result is
// loaded after the check state; with one, after five serial multiplies and a divide.
// A new beat is not taken until the result is loaded into the output register.
// Reset clears state to the initial controller state and gains to defaults.
module ph_pid_pump_controller_unit import phpid_pkg::*; #(
  parameter  int unsigned TIME_BITS  = TIME_BITS_DEF,
  localparam int unsigned IN_TDATA_W = ((PH_W + TIME_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // ph_sample, time_ms
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // error_out, control_out, base_duty, acid_duty
  output logic                   m_axis_tuser_o,  // updated
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_CHECK  = 15'h0002,
    ST_MUL_Y  = 15'h0004,
    ST_LD_YT  = 15'h0008,
    ST_MUL_YT = 15'h0010,
    ST_LD_KP  = 15'h0020,
    ST_MUL_KP = 15'h0040,
    ST_LD_AT  = 15'h0080,
    ST_MUL_AT = 15'h0100,
    ST_LD_KD  = 15'h0200,
    ST_MUL_KD = 15'h0400,
    ST_NORM   = 15'h0800,
    ST_DIV    = 15'h1000,
    ST_FIN    = 15'h2000,
    ST_OUT    = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic [GAIN_W-1:0] kp_q, ki_q, kd_q, per_q;
  logic [PH_W-1:0]   sp_q;

  logic [PH_W-1:0]         ph_q;
  logic [TIME_BITS-1:0]    time_q, last_q, delta;
  logic signed [ERR_W-1:0] prev_q, herr_q, e_q, e_c;
  logic signed [DERR_W-1:0] de_q, de_c;
  logic [INTEG_W-1:0]      integ_q, integ_c;
  logic signed [ISUM_W-1:0] isum;
  logic                    dir_q;
  logic [CTRL_W-1:0]       hctrl_q, hctrl_c, mag9, hmag9;
  logic                    upd_q, neg_q, sat_q;
  logic [GAIN_W-1:0]       t_eff;
  logic                    go;

  logic signed [ACC_W-1:0] acc;
  logic                    mac_done, div_done;
  logic [QUO_W-1:0]        quo;
  mac_ctrl_t               mac_c;
  div_req_t                div_c;
  logic [A_W-1:0]          a_cl;
  logic [ACC_W-1:0]        absn;
  logic [NUM_W-1:0]        nmag;
  logic                    sat_c;
  logic [DUTY_W-1:0]       hmag, base_c, acid_c;

  logic                    m_valid_q;
  logic [OUT_TDATA_W-1:0]  m_data_q;
  logic                    m_user_q;
  logic                    load;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  assign t_eff = (per_q == '0) ? GAIN_W'(1) : per_q;
  assign delta = time_q - last_q;
  assign go    = (delta >= TIME_BITS'(t_eff));

  assign e_c  = ERR_W'({1'b0, sp_q}) - ERR_W'({1'b0, ph_q});
  assign de_c = {e_c[ERR_W-1], e_c} - {prev_q[ERR_W-1], prev_q};
  assign isum = {2'b00, integ_q} + {{(ISUM_W-ERR_W){e_c[ERR_W-1]}}, e_c};

  always_comb begin
    if (e_c == '0 || isum[ISUM_W-1]) begin
      integ_c = '0;
    end else if (isum[ISUM_W-2:0] > (ISUM_W-1)'(INTEG_MAX)) begin
      integ_c = INTEG_MAX;
    end else begin
      integ_c = isum[INTEG_W-1:0];
    end
  end

  always_comb begin
    if (acc > A_LIM) begin
      a_cl = A_W'(A_LIM);
    end else if (acc < A_LIM_N) begin
      a_cl = A_W'(A_LIM_N);
    end else begin
      a_cl = acc[A_W-1:0];
    end
  end

  assign absn  = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
  assign nmag  = absn[ACC_W-1:FRAC_W];
  assign sat_c = (nmag >= NUM_W'({t_eff, QUO_W'(0)}));

  assign mag9    = {1'b0, (sat_q ? {QUO_W{1'b1}} : quo)};
  assign hctrl_c = neg_q ? (~mag9 + 1'b1) : mag9;

  assign hmag9  = hctrl_q[CTRL_W-1] ? (~hctrl_q + 1'b1) : hctrl_q;
  assign hmag   = hmag9[DUTY_W-1:0];
  assign base_c = dir_q ? hmag : '0;
  assign acid_c = dir_q ? '0 : hmag;

  assign load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    mac_c = '0;
    unique case (state_q)
      ST_CHECK: begin
        mac_c.start = go;
        mac_c.clear = 1'b1;
        mac_c.mcand = MC_W'(integ_c);
        mac_c.mult  = ki_q;
      end
      ST_LD_YT: begin
        mac_c.start = 1'b1;
        mac_c.clear = 1'b1;
        mac_c.mcand = {1'b0, acc[Y_W-1:0]};
        mac_c.mult  = t_eff;
      end
      ST_LD_KP: begin
        mac_c.start = 1'b1;
        mac_c.mcand = {{(MC_W-ERR_W){e_q[ERR_W-1]}}, e_q};
        mac_c.mult  = kp_q;
      end
      ST_LD_AT: begin
        mac_c.start = 1'b1;
        mac_c.clear = 1'b1;
        mac_c.mcand = a_cl;
        mac_c.mult  = t_eff;
      end
      ST_LD_KD: begin
        mac_c.start = 1'b1;
        mac_c.mcand = {{(MC_W-DERR_W){de_q[DERR_W-1]}}, de_q};
        mac_c.mult  = kd_q;
      end
      default: begin
        mac_c = '0;
      end
    endcase
  end

  always_comb begin
    div_c          = '0;
    div_c.start    = (state_q == ST_NORM);
    div_c.dividend = nmag[DIVD_W-1:0];
    div_c.divisor  = t_eff;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = go ? ST_MUL_Y : ST_OUT;
      ST_MUL_Y:  if (mac_done) state_d = ST_LD_YT;
      ST_LD_YT:  state_d = ST_MUL_YT;
      ST_MUL_YT: if (mac_done) state_d = ST_LD_KP;
      ST_LD_KP:  state_d = ST_MUL_KP;
      ST_MUL_KP: if (mac_done) state_d = ST_LD_AT;
      ST_LD_AT:  state_d = ST_MUL_AT;
      ST_MUL_AT: if (mac_done) state_d = ST_LD_KD;
      ST_LD_KD:  state_d = ST_MUL_KD;
      ST_MUL_KD: if (mac_done) state_d = ST_NORM;
      ST_NORM:   state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_FIN;
      ST_FIN:    state_d = ST_OUT;
      ST_OUT:    if (load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= KP_RST;
      ki_q  <= KI_RST;
      kd_q  <= KD_RST;
      per_q <= PERIOD_RST;
      sp_q  <= SP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KP:     kp_q  <= cfg_wdata_i;
        CFG_KI:     ki_q  <= cfg_wdata_i;
        CFG_KD:     kd_q  <= cfg_wdata_i;
        CFG_PERIOD: per_q <= cfg_wdata_i;
        CFG_SP:     sp_q  <= cfg_wdata_i[PH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      prev_q  <= '0;
      herr_q  <= '0;
      integ_q <= '0;
      dir_q   <= 1'b1;
      hctrl_q <= '0;
    end else begin
      if (state_q == ST_CHECK && go) begin
        last_q  <= time_q;
        prev_q  <= e_c;
        herr_q  <= e_c;
        integ_q <= integ_c;
        if (e_c != '0) begin
          dir_q <= !e_c[ERR_W-1];
        end
      end
      if (state_q == ST_FIN) begin
        hctrl_q <= hctrl_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      ph_q   <= s_axis_tdata_i[PH_W-1:0];
      time_q <= s_axis_tdata_i[PH_W +: TIME_BITS];
    end
    if (state_q == ST_CHECK) begin
      e_q   <= e_c;
      de_q  <= de_c;
      upd_q <= go;
    end
    if (state_q == ST_NORM) begin
      neg_q <= acc[ACC_W-1];
      sat_q <= sat_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= OUT_TDATA_W'({acid_c, base_c, hctrl_q, herr_q});
      m_user_q <= upd_q;
    end
  end

  phpid_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_c),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  phpid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_c),
    .quo_o  (quo),
    .done_o (div_done)
  );

endmodule

// ===== src/phpid_mac.sv =====
// Serial multiply-accumulate unit: two multiplier bits per cycle, shifted
// multiplicand. Depends on phpid_pkg.
module phpid_mac import phpid_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    done_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] mc_q, mc_d;
  logic signed [ACC_W-1:0] pp;
  logic [GAIN_W-1:0]       mr_q, mr_d;
  logic [MAC_CNT_W-1:0]    cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    last;

  assign last   = (cnt_q == MAC_CNT_W'(MAC_STEPS - 1));
  assign done_o = busy_q && last;
  assign acc_o  = acc_q;

  always_comb begin
    pp     = '0;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mr_d   = mr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (mr_q[0]) begin
      pp = mc_q;
    end
    if (mr_q[1]) begin
      pp = pp + (mc_q <<< 1);
    end
    if (busy_q) begin
      acc_d = acc_q + pp;
      mc_d  = mc_q <<< DIGIT_W;
      mr_d  = mr_q >> DIGIT_W;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (ctrl_i.start) begin
      mc_d   = {{(ACC_W-MC_W){ctrl_i.mcand[MC_W-1]}}, ctrl_i.mcand};
      mr_d   = ctrl_i.mult;
      cnt_d  = '0;
      busy_d = 1'b1;
      if (ctrl_i.clear) begin
        acc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mr_q  <= mr_d;
  end

endmodule

// ===== src/phpid_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known below 2^QUO_W.
// Depends on phpid_pkg.
module phpid_div import phpid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             done_o
);

  logic [DIVD_W-1:0]    rem_q, rem_d;
  logic [DIVD_W-2:0]    dv_q, dv_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 ge;
  logic                 last;

  assign ge     = (rem_q >= {1'b0, dv_q});
  assign last   = (cnt_q == DIV_CNT_W'(QUO_W - 1));
  assign done_o = busy_q && last;
  assign quo_o  = quo_q;

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - {1'b0, dv_q};
      end
      quo_d = {quo_q[QUO_W-2:0], ge};
      dv_d  = dv_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (req_i.start) begin
      rem_d  = req_i.dividend;
      dv_d   = {req_i.divisor, (QUO_W-1)'(0)};
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
  end

endmodule

// ===== src/phpid_chk.sv =====
// Port-level checker for the pH PID pump controller, bound to the top level.
// Depends on phpid_pkg and ph_pid_pump_controller_unit_macros.svh.
`include "ph_pid_pump_controller_unit_macros.svh"

module phpid_chk import phpid_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // error_out, control_out, base_duty, acid_duty
  input logic                   m_axis_tuser_o   // updated
);

  logic [CTRL_W-1:0] ctl;
  logic [DUTY_W-1:0] mag, base, acid;

  assign ctl  = m_axis_tdata_o[CTRL_LSB +: CTRL_W];
  assign mag  = ctl[CTRL_W-1] ? DUTY_W'(~ctl + 1'b1) : ctl[DUTY_W-1:0];
  assign base = m_axis_tdata_o[BASE_LSB +: DUTY_W];
  assign acid = m_axis_tdata_o[ACID_LSB +: DUTY_W];

  `PHPID_ASSERT_ALWAYS(a_no_beat_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result beat during reset")

  `PHPID_ASSERT(a_one_pump, clk_i, rst_ni, m_axis_tvalid_o |-> (base == '0 || acid == '0), "both pumps driven")

  `PHPID_ASSERT(a_duty_mag, clk_i, rst_ni, m_axis_tvalid_o |-> ((base | acid) == mag), "duty differs from control magnitude")

  `PHPID_ASSERT(a_one_in_flight, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "input taken while busy")

  `PHPID_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)), "stalled result beat changed")

endmodule

bind ph_pid_pump_controller_unit phpid_chk u_phpid_chk (.*);

// ===== sim/ph_pid_dosing_monitor.sv =====
// Dosing monitor for the pH PID pump controller testbench: watches the sample,
// register and result beats, recomputes each controller result and compares it.
// Depends on phpid_pkg.
module ph_pid_dosing_monitor import phpid_pkg::*; #(
  parameter int unsigned IN_W = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_W-1:0]        s_axis_tdata_i,  // ph_sample, time_ms
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,  // error_out, control_out, base_duty, acid_duty
  input  logic                   m_axis_tuser_i,  // updated
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output int unsigned            mismatches_o,
  output int unsigned            in_flight_o
);

  localparam longint CTRL_LIM  = 255;
  localparam longint INTEG_TOP = 65280;
  localparam longint A_CLAMP   = 64'sd2147483648;

  typedef struct packed {
    logic                     updated;
    logic signed [ERR_W-1:0]  err;
    logic signed [CTRL_W-1:0] ctrl;
    logic [DUTY_W-1:0]        base;
    logic [DUTY_W-1:0]        acid;
  } dosing_t;

  logic [GAIN_W-1:0] kp, ki, kd, period;
  logic [PH_W-1:0]   setpoint;
  logic [31:0]       last_stamp;
  longint            prev_err, held_err, integ, held_ctrl;
  bit                base_dir;
  dosing_t           dosing_q[$];
  int unsigned       samples_in, results_out, mismatches;

  assign mismatches_o = mismatches;
  assign in_flight_o  = samples_in - results_out;

  function automatic dosing_t predict_dosing(input logic [PH_W-1:0] ph, input logic [31:0] now);
    longint      t, e, de, a, num, q, mag;
    logic [31:0] delta;
    dosing_t     r;
    t = (period == '0) ? 64'sd1 : longint'(period);
    delta = now - last_stamp;
    r.updated = 1'b0;
    if (longint'(delta) >= t) begin
      e = longint'(setpoint) - longint'(ph);
      de = e - prev_err;
      integ = (e == 0) ? 64'sd0 : integ + e;
      if (integ > INTEG_TOP) integ = INTEG_TOP;
      if (integ < 0) integ = 0;
      if (e < 0) base_dir = 1'b0;
      else if (e > 0) base_dir = 1'b1;
      prev_err = e;
      held_err = e;
      a = longint'(kp) * e + longint'(ki) * integ * t;
      if (a > A_CLAMP) a = A_CLAMP;
      if (a < -A_CLAMP) a = -A_CLAMP;
      num = a * t + longint'(kd) * de;
      q = num / (t * 65536);
      if (q > CTRL_LIM) q = CTRL_LIM;
      if (q < -CTRL_LIM) q = -CTRL_LIM;
      held_ctrl = q;
      last_stamp = now;
      r.updated = 1'b1;
    end
    mag = (held_ctrl < 0) ? -held_ctrl : held_ctrl;
    r.err  = ERR_W'(held_err);
    r.ctrl = CTRL_W'(held_ctrl);
    r.base = base_dir ? DUTY_W'(mag) : '0;
    r.acid = base_dir ? '0 : DUTY_W'(mag);
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dosing_t got, want;
    if (!rst_ni) begin
      kp = KP_RST;
      ki = KI_RST;
      kd = KD_RST;
      period = PERIOD_RST;
      setpoint = SP_RST;
      last_stamp = '0;
      prev_err = 0;
      held_err = 0;
      integ = 0;
      base_dir = 1'b1;
      held_ctrl = 0;
      dosing_q.delete();
      mismatches = 0;
      samples_in <= 0;
      results_out <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KP:     kp = cfg_wdata_i;
          CFG_KI:     ki = cfg_wdata_i;
          CFG_KD:     kd = cfg_wdata_i;
          CFG_PERIOD: period = cfg_wdata_i;
          CFG_SP:     setpoint = cfg_wdata_i[PH_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        dosing_q.push_back(predict_dosing(s_axis_tdata_i[PH_W-1:0],
                                          s_axis_tdata_i[PH_W +: 32]));
        samples_in <= samples_in + 1;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.updated = m_axis_tuser_i;
        got.err     = m_axis_tdata_i[ERR_LSB +: ERR_W];
        got.ctrl    = m_axis_tdata_i[CTRL_LSB +: CTRL_W];
        got.base    = m_axis_tdata_i[BASE_LSB +: DUTY_W];
        got.acid    = m_axis_tdata_i[ACID_LSB +: DUTY_W];
        if (dosing_q.size() == 0) begin
          $error("result beat with no sample pending");
          mismatches++;
        end else begin
          want = dosing_q.pop_front();
          results_out <= results_out + 1;
          flag_field("updated", 16'(want.updated), 16'(got.updated));
          flag_field("error_out", 16'(want.err), 16'(got.err));
          flag_field("control_out", 16'(want.ctrl), 16'(got.ctrl));
          flag_field("base_duty", 16'(want.base), 16'(got.base));
          flag_field("acid_duty", 16'(want.acid), 16'(got.acid));
        end
      end
    end
  end

endmodule

// ===== sim/tb_ph_pid_pump_controller_unit.sv =====
// Testbench top for ph_pid_pump_controller_unit: drives pH sample beats,
// register writes and result-side pacing, then reports the verdict.
// Depends on phpid_pkg and ph_pid_dosing_monitor.
module tb_ph_pid_pump_controller_unit;
  import phpid_pkg::*;

  localparam int unsigned TIME_W        = TIME_BITS_DEF;
  localparam int unsigned IN_W          = ((PH_W + TIME_W + 7) / 8) * 8;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_ITEMS   = 147;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_W-1:0]        s_axis_tdata_i = '0;  // ph_sample, time_ms
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;       // error_out, control_out, base_duty, acid_duty
  logic                   m_axis_tuser_o;       // updated
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  int unsigned       mismatches, in_flight;
  logic [TIME_W-1:0] stamp_ms = '0;
  logic [GAIN_W-1:0] cur_period = PERIOD_RST;
  logic [PH_W-1:0]   cur_setpoint = SP_RST;
  bit                tx_quiet = 1'b0;
  bit                rx_quiet = 1'b0;
  int unsigned       hold_reqs = 0;
  int unsigned       holds_served = 0;

  ph_pid_pump_controller_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  ph_pid_dosing_monitor #(.IN_W(IN_W)) u_dosing_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mismatches_o    (mismatches),
    .in_flight_o     (in_flight)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_idle(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp();
    int unsigned r, t;
    r = $urandom_range(0, 99);
    t = (cur_period == '0) ? 1 : cur_period;
    if (r < 45) return stamp_ms + t + $urandom_range(0, 2);
    if (r < 60) return stamp_ms + $urandom_range(0, t - 1);
    if (r < 85) return stamp_ms + $urandom_range(0, 3 * t);
    if (r < 92) return stamp_ms;
    return TIME_W'($urandom());
  endfunction

  function automatic logic [PH_W-1:0] next_ph(input int bias);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 30) return PH_W'($urandom_range(0, 4095));
    if (r < 40) return cur_setpoint;
    if (r < 75) v = int'(cur_setpoint) - bias * int'($urandom_range(0, 3000));
    else v = int'(cur_setpoint) + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return PH_W'(v);
  endfunction

  task automatic send_sample(input logic [PH_W-1:0] ph, input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    gap = pick_idle(tx_quiet);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    stamp_ms = stamp;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= IN_W'({stamp, ph});
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] per,
                                input logic [PH_W-1:0] sp);
    settle();
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_KD, kd);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_SP, {4'($urandom()), sp});
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
    cfg_we_i <= 1'b0;
    cur_period = per;
    cur_setpoint = sp;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 70) return GAIN_W'($urandom_range(0, 1023));
    return GAIN_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [GAIN_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 60) return GAIN_W'($urandom_range(1, 16));
    if (r < 85) return GAIN_W'($urandom_range(17, 1000));
    return GAIN_W'($urandom_range(1001, 65535));
  endfunction

  function automatic logic [PH_W-1:0] pick_setpoint();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return PH_W'($urandom_range(0, 3584));
  endfunction

  always begin : result_pacing
    int unsigned stall;
    @(posedge clk_i);
    if (hold_reqs != holds_served) begin
      m_axis_tready_i <= 1'b0;
      repeat (LONG_HOLD) @(posedge clk_i);
      holds_served = holds_served + 1;
    end else begin
      stall = pick_idle(rx_quiet);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int bias;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_sample(12'd1280, 32'd5);
    send_sample(12'd1280, 32'd10);
    send_sample(12'd0, 32'd20);
    send_sample(12'd4095, 32'd30);
    send_sample(12'd1280, 32'd40);
    send_sample(12'd3584, 32'd49);
    send_sample(12'd3584, 32'd50);
    send_sample(12'd4095, 32'hFFFF_FFF8);
    send_sample(12'd0, 32'd2);
    send_sample(12'd2048, 32'd3);
    send_sample(12'd1281, 32'd12);
    send_sample(12'd1279, 32'd22);

    apply_settings('1, '1, '1, '0, '1);
    repeat (5) send_sample(12'd0, stamp_ms + 1);
    send_sample(12'd0, stamp_ms);
    send_sample(12'd4095, stamp_ms + 1);
    send_sample(12'd0, stamp_ms + 7);

    apply_settings('0, '0, '0, '1, '0);
    send_sample(12'd0, stamp_ms + 32'd65535);
    send_sample(12'd4095, stamp_ms + 32'd65534);
    send_sample(12'd4095, stamp_ms + 32'd1);

    for (int p = 0; p < PHASES; p++) begin
      apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_period(), pick_setpoint());
      tx_quiet <= ($urandom_range(0, 3) == 0);
      rx_quiet <= ($urandom_range(0, 3) == 0);
      bias = ($urandom_range(0, 1) != 0) ? 1 : -1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 20) begin
          hold_reqs <= hold_reqs + 1;
          tx_quiet <= 1'b1;
        end else if (i % 50 == 49) begin
          tx_quiet <= !tx_quiet;
          rx_quiet <= ($urandom_range(0, 2) == 0);
        end
        send_sample(next_ph(bias), next_stamp());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
